// ===== design/blss_pkg.sv =====
// shared types and constants for the bounded lifo stack with search
`timescale 1ns / 1ps
`default_nettype none

package blss_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CNT_W         = 5;

   localparam logic [CNT_W-1:0]  CAP_RESET      = 5'd16;
   localparam logic [DATA_W-1:0] EMPTY_POP_DATA = '1;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } state_type;

   typedef struct packed {
      logic exec;
      logic finish_search;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ===== design/blss_ctrl.sv =====
// controller state machine for the lifo stack
`timescale 1ns / 1ps
`default_nettype none

module blss_ctrl
   import blss_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire op_type       op,
   output logic              busy,
   output ctrl_cmd_type      cmd,
   output logic              rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && (op == OP_SEARCH)) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy              = 1'b0;
      cmd.exec          = 1'b0;
      cmd.finish_search = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.exec = start;
         end
         S_SEARCH: begin
            busy              = 1'b1;
            cmd.finish_search = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (cmd.exec && (op != OP_SEARCH)) || cmd.finish_search;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_search_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |=> (state_ff == S_IDLE))
      else $error("search state held longer than one cycle");

   a_simple_op_responds: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op != OP_SEARCH)) |=> rsp_valid_ff)
      else $error("no response after push, pop or peek");

   a_search_responds: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op == OP_SEARCH)) |=> (!rsp_valid_ff ##1 rsp_valid_ff))
      else $error("search response not two cycles after request");
`endif

endmodule

`default_nettype wire

// ===== design/blss_datapath.sv =====
// stack storage, count, limit register and result registers
`timescale 1ns / 1ps
`default_nettype none

module blss_datapath
   import blss_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   input  wire op_type                   op,
   input  wire logic signed [DATA_W-1:0] data_value,
   input  wire logic                     csr_write_enable,
   input  wire logic [CNT_W-1:0]         csr_write_data,
   output logic signed [DATA_W-1:0]      read_value,
   output logic                          found,
   output logic [1:0]                    status,
   output logic [CNT_W-1:0]              entry_count,
   output logic                          is_empty,
   output logic                          is_full
);

   // the limit register is 5 bits, so no more than 31 entries are ever reachable
   localparam int CAP_MAX     = (1 << CNT_W) - 1;
   localparam int STORE_DEPTH = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(STORE_DEPTH);

   logic [DATA_W-1:0]      store_ff [STORE_DEPTH];
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic [CNT_W-1:0]       limit_ff;
   logic [STORE_DEPTH-1:0] match_ff,  match_in;
   logic [DATA_W-1:0]      rd_ff,     rd_in;
   logic                   found_ff,  found_in;
   status_type             status_ff, status_in;
   logic                   empty_ff,  full_ff;

   logic [CNT_W-1:0]  eff_limit;
   logic              at_limit;
   logic [ADDR_W-1:0] top_idx;
   logic              push_en;

   assign eff_limit = (limit_ff > DEPTH_CAP) ? DEPTH_CAP : limit_ff;
   assign at_limit  = (count_ff >= eff_limit);
   assign top_idx   = ADDR_W'(count_ff - 5'd1);

   // per-entry compare against the key, masked by occupancy
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < count_ff) && (store_ff[i] == data_value);
      end
   end

   always_comb begin
      count_in  = count_ff;
      rd_in     = rd_ff;
      found_in  = found_ff;
      status_in = status_ff;
      push_en   = 1'b0;
      if (cmd.exec) begin
         rd_in     = '0;
         found_in  = 1'b0;
         status_in = ST_OK;
         unique case (op)
            OP_PUSH: begin
               if (at_limit) begin
                  status_in = ST_FULL;
               end else begin
                  push_en  = 1'b1;
                  count_in = count_ff + 5'd1;
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  rd_in     = EMPTY_POP_DATA;
                  status_in = ST_EMPTY;
               end else begin
                  rd_in    = store_ff[top_idx];
                  count_in = count_ff - 5'd1;
               end
            end
            OP_PEEK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_in = store_ff[top_idx];
               end
            end
            OP_SEARCH: begin
               found_in = 1'b0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end else if (cmd.finish_search) begin
         found_in = |match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         store_ff[ADDR_W'(count_ff)] <= data_value;
      end
      if (cmd.exec) begin
         match_ff <= match_in;
      end
      rd_ff     <= rd_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      empty_ff  <= (count_in == '0);
      full_ff   <= (count_in >= eff_limit);
   end

   assign read_value  = rd_ff;
   assign found       = found_ff;
   assign status      = status_ff;
   assign entry_count = count_ff;
   assign is_empty    = empty_ff;
   assign is_full     = full_ff;

`ifndef SYNTH
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CAP)
      else $error("entry count beyond storage");

   a_count_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_full_push_no_store: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op == OP_PUSH) && at_limit) |=> (status_ff == ST_FULL))
      else $error("push at limit not refused");
`endif

endmodule

`default_nettype wire

// ===== design/bounded_lifo_stack_with_search.sv =====
// top level of the bounded lifo stack with content search
`timescale 1ns / 1ps
`default_nettype none

// push, pop and peek: result strobe in the cycle after the request, a new request every cycle while busy is low
// search: busy high for one cycle in the search state, and the result strobe is registered after that state
//   (the key compare lands in a registered match vector that is or-reduced next cycle)
// results cannot be held off by the receiver; rsp_valid is high for one cycle only
// synchronous reset: entry count cleared, capacity limit set to 16, entries not cleared
module bounded_lifo_stack_with_search
   import blss_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   // request channel
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_operation,
   input  wire logic signed [DATA_W-1:0] req_data_value,

   // result channel, one-cycle strobe
   output logic                          rsp_valid,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic                          rsp_found,
   output logic [1:0]                    rsp_status,
   output logic [CNT_W-1:0]              rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,

   // capacity limit register
   input  wire logic                     csr_write_enable,
   input  wire logic [CNT_W-1:0]         csr_write_data
);

   op_type       op;
   ctrl_cmd_type cmd;

   // all four operation codes are meaningful, so the cast is total
   assign op = op_type'(req_operation);

   // controller: accepts requests and sequences the two-step search
   blss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (op),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // datapath: storage, count, limit and registered result fields
   blss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .op               (op),
      .data_value       (req_data_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .read_value       (rsp_read_value),
      .found            (rsp_found),
      .status           (rsp_status),
      .entry_count      (rsp_entry_count),
      .is_empty         (rsp_is_empty),
      .is_full          (rsp_is_full)
   );

endmodule

`default_nettype wire
